/* design/mpss_pkg.sv */
package mpss_pkg;

  // default sizes
  localparam int unsigned MaxTasksDef   = 64;
  localparam int unsigned NumStrandsDef = 4;

  // one stored task
  typedef struct packed {
    logic [7:0] task_id;
    logic [1:0] strand;
    logic [7:0] prio;
  } entry_t;

  // input record
  typedef struct packed {
    logic [7:0] task_id;
    logic [1:0] strand;
    logic [7:0] priority_req;
    logic       schedulable;
    logic       last_record;
  } in_t;

  // schedule result
  typedef struct packed {
    logic [7:0] out_task_id;
    logic [1:0] out_strand;
    logic [7:0] out_priority;
    logic       end_of_schedule;
    logic       schedule_empty;
    logic       overflow;
  } out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // true if a must be placed ahead of an already stored b
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.strand != b.strand) begin
      res = a.strand < b.strand;
    end else begin
      res = a.prio > b.prio;
    end
    return res;
  endfunction

endpackage

/* design/multilevel_priority_schedule_sort.sv */
// Load: one record per cycle while in_stall_o is low, each inserted into a
// sorted chain of cells in the cycle it transfers; the chain compares the
// record in every cell at once. Emit: the record marked last starts the drain;
// the head entry is then registered as output (an empty load gets the empty
// marker instead), one result per cycle from the head cell while out_stall_i
// is low, input stalled. Reset clears the task count, overflow flag and
// handshake state; cells are not reset and only occupied cells are ever read.
module multilevel_priority_schedule_sort #(
  parameter int unsigned MaxTasks   = mpss_pkg::MaxTasksDef,
  parameter int unsigned NumStrands = mpss_pkg::NumStrandsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mpss_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mpss_pkg::out_t  out_data_o
);

  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic {
    PhLoad,
    PhEmit
  } phase_e;

  phase_e                 phase_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_next;
  logic                   ovf_q;
  logic                   out_valid_q;
  logic                   out_valid_d;
  mpss_pkg::out_t         out_q;
  mpss_pkg::out_t         out_d;

  logic                   in_xfer;
  logic                   has_room;
  logic                   do_insert;
  logic                   load_done;
  logic                   pop;
  mpss_pkg::entry_t       new_entry;
  mpss_pkg::cell_ctrl_t   ctrl;

  mpss_pkg::entry_t       cell_entry [MaxTasks];
  logic                   cell_flag  [MaxTasks];

  // input side handshake
  assign in_stall_o = (phase_q == PhEmit) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign has_room   = count_q < CntW'(MaxTasks);
  assign do_insert  = in_xfer && in_data_i.schedulable && has_room;
  assign count_next = do_insert ? count_q + CntW'(1) : count_q;
  assign load_done  = (phase_q == PhLoad) && in_xfer && in_data_i.last_record;

  // strand saturation
  always_comb begin
    new_entry.task_id = in_data_i.task_id;
    new_entry.prio    = in_data_i.priority_req;
    if (int'(in_data_i.strand) >= int'(NumStrands)) begin
      new_entry.strand = 2'(NumStrands - 1);
    end else begin
      new_entry.strand = in_data_i.strand;
    end
  end

  // drain one entry per free output slot
  assign pop         = (phase_q == PhEmit) && (!out_valid_q || !out_stall_i);
  assign ctrl.insert = do_insert;
  assign ctrl.drain  = pop;

  // chain of cells, head at index zero
  for (genvar i = 0; i < MaxTasks; i++) begin : g_cell
    mpss_pkg::entry_t prev_entry, next_entry;
    logic             prev_flag;
    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_flag  = 1'b0;
    end else begin : g_body
      assign prev_entry = cell_entry[i-1];
      assign prev_flag  = cell_flag[i-1];
    end
    if (i == MaxTasks - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end
    mpss_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occupied_i   (CntW'(i) < count_q),
      .prev_entry_i (prev_entry),
      .prev_flag_i  (prev_flag),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[i]),
      .flag_o       (cell_flag[i])
    );
  end

  // next output slot: empty marker at load end, or the head entry on a drain
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (load_done && (count_next == '0)) begin
      out_valid_d          = 1'b1;
      out_d                = '0;
      out_d.schedule_empty = 1'b1;
    end else if (pop) begin
      out_valid_d           = 1'b1;
      out_d.out_task_id     = cell_entry[0].task_id;
      out_d.out_strand      = cell_entry[0].strand;
      out_d.out_priority    = cell_entry[0].prio;
      out_d.end_of_schedule = (count_q == CntW'(1));
      out_d.schedule_empty  = 1'b0;
      out_d.overflow        = ovf_q;
    end
  end

  // phase, count, overflow and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLoad;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      unique case (phase_q)
        PhLoad: begin
          if (in_xfer) begin
            count_q <= count_next;
            if (in_data_i.schedulable && !has_room) begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.last_record) begin
              if (count_next == '0) begin
                ovf_q <= 1'b0;
              end else begin
                phase_q <= PhEmit;
              end
            end
          end
        end
        PhEmit: begin
          if (pop) begin
            count_q <= count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              phase_q <= PhLoad;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: phase_q <= PhLoad;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/mpss_cell.sv */
module mpss_cell (
  input  logic                clk_i,
  input  mpss_pkg::cell_ctrl_t ctrl_i,
  input  mpss_pkg::entry_t    new_entry_i,
  input  logic                occupied_i,
  input  mpss_pkg::entry_t    prev_entry_i,
  input  logic                prev_flag_i,
  input  mpss_pkg::entry_t    next_entry_i,
  output mpss_pkg::entry_t    entry_o,
  output logic                flag_o
);

  mpss_pkg::entry_t entry_q, entry_d;
  logic             flag;

  // new record lands at or above this cell
  assign flag = !occupied_i || mpss_pkg::goes_before(new_entry_i, entry_q);

  // insert: shift down from the upper neighbor or take the new record
  // drain: take the lower neighbor's entry
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && flag) begin
      entry_d = prev_flag_i ? prev_entry_i : new_entry_i;
    end else if (ctrl_i.drain) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign flag_o  = flag;

endmodule

/* sim/multilevel_priority_schedule_sort_tb.sv */
module multilevel_priority_schedule_sort_tb;

  localparam int unsigned MaxTasks    = mpss_pkg::MaxTasksDef;
  localparam int unsigned NumStrands  = mpss_pkg::NumStrandsDef;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned RandItems   = 90;
  localparam int unsigned MaxShown    = 10;

  // empty schedule: only the empty flag is set
  localparam mpss_pkg::out_t EmptySched = {8'h00, 2'd0, 8'h00, 1'b0, 1'b1, 1'b0};

  // one row of the directed table
  typedef struct {
    mpss_pkg::in_t  rec;
    bit             typed;
    mpss_pkg::out_t want;
  } stim_row_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  mpss_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  mpss_pkg::out_t out_data_o;

  // typed expectation that travels with the record being driven
  bit             row_typed   = 1'b0;
  mpss_pkg::out_t row_want    = '0;

  // predictor state and expected schedule items
  mpss_pkg::entry_t sorted_tasks[$];
  bit               drop_seen;
  mpss_pkg::out_t   pending_sched[$];

  int unsigned n_fail      = 0;
  int unsigned n_sent      = 0;
  int unsigned n_results   = 0;
  int unsigned n_loads     = 0;
  int unsigned n_ovf_loads = 0;
  int unsigned n_empty     = 0;
  int unsigned burst_left  = 0;

  stim_row_t dir_tab[$];

  multilevel_priority_schedule_sort #(
    .MaxTasks  (MaxTasks),
    .NumStrands(NumStrands)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // a ranks ahead of an already stored b: lower strand, then higher priority
  function automatic bit ranks_ahead(mpss_pkg::entry_t a, mpss_pkg::entry_t b);
    return (a.strand < b.strand) || (a.strand == b.strand && a.prio > b.prio);
  endfunction

  // file one accepted record; the record marked last releases the schedule
  function automatic void file_record(mpss_pkg::in_t rec, bit typed, mpss_pkg::out_t want);
    mpss_pkg::entry_t e;
    mpss_pkg::out_t   item;
    int               pos;
    int               k;
    if (rec.schedulable) begin
      e.task_id = rec.task_id;
      e.strand  = rec.strand;
      e.prio    = rec.priority_req;
      if (e.strand >= NumStrands) begin
        e.strand = 2'(NumStrands - 1);
      end
      if (sorted_tasks.size() >= MaxTasks) begin
        drop_seen = 1'b1;
      end else begin
        pos = 0;
        while (pos < sorted_tasks.size() && !ranks_ahead(e, sorted_tasks[pos])) begin
          pos++;
        end
        sorted_tasks.insert(pos, e);
      end
    end
    if (!rec.last_record) begin
      return;
    end
    n_loads++;
    if (drop_seen) begin
      n_ovf_loads++;
    end
    if (sorted_tasks.size() == 0) begin
      n_empty++;
    end
    if (typed) begin
      pending_sched.push_back(want);
    end else if (sorted_tasks.size() == 0) begin
      pending_sched.push_back(EmptySched);
    end else begin
      for (k = 0; k < sorted_tasks.size(); k++) begin
        item.out_task_id     = sorted_tasks[k].task_id;
        item.out_strand      = sorted_tasks[k].strand;
        item.out_priority    = sorted_tasks[k].prio;
        item.end_of_schedule = (k == sorted_tasks.size() - 1);
        item.schedule_empty  = 1'b0;
        item.overflow        = drop_seen;
        pending_sched.push_back(item);
      end
    end
    sorted_tasks.delete();
    drop_seen = 1'b0;
  endfunction

  // monitor both channels; prediction runs before the check in the same edge
  always @(posedge clk_i) begin
    mpss_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        file_record(in_data_i, row_typed, row_want);
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_sched.size() == 0) begin
          n_fail++;
          if (n_fail <= MaxShown) begin
            $display("unexpected schedule item: id %h strand %0d prio %h eos %b empty %b ovf %b",
                     out_data_o.out_task_id, out_data_o.out_strand,
                     out_data_o.out_priority, out_data_o.end_of_schedule,
                     out_data_o.schedule_empty, out_data_o.overflow);
          end
        end else begin
          want = pending_sched.pop_front();
          if (out_data_o !== want) begin
            n_fail++;
            if (n_fail <= MaxShown) begin
              $display("schedule item %0d mismatch: want id %h strand %0d prio %h eos %b empty %b ovf %b",
                       n_results, want.out_task_id, want.out_strand, want.out_priority,
                       want.end_of_schedule, want.schedule_empty, want.overflow);
              $display("                         got  id %h strand %0d prio %h eos %b empty %b ovf %b",
                       out_data_o.out_task_id, out_data_o.out_strand,
                       out_data_o.out_priority, out_data_o.end_of_schedule,
                       out_data_o.schedule_empty, out_data_o.overflow);
            end
          end
        end
      end
    end
  end

  // receiver stall pattern: free running, light random, or heavy stretches
  always @(posedge clk_i) begin
    static int stall_mode = 0;
    static int mode_left  = 0;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(8, 40);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic stim_row_t mk_row(logic [7:0] id, logic [1:0] st, logic [7:0] pr,
                                       logic sc, logic la, bit typed,
                                       mpss_pkg::out_t want);
    stim_row_t r;
    r.rec.task_id      = id;
    r.rec.strand       = st;
    r.rec.priority_req = pr;
    r.rec.schedulable  = sc;
    r.rec.last_record  = la;
    r.typed            = typed;
    r.want             = want;
    return r;
  endfunction

  // drive one record until its transfer, then maybe open a gap
  task automatic send_record(mpss_pkg::in_t rec, bit typed, mpss_pkg::out_t want);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= rec;
    row_typed  <= typed;
    row_want   <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the sender until the whole expected schedule has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sched.size() != 0) @(posedge clk_i);
  endtask

  // one load of random records; only the final one is marked last
  task automatic send_load(int unsigned n_recs, int unsigned sched_pct, bit narrow);
    mpss_pkg::in_t rec;
    int unsigned   i;
    for (i = 0; i < n_recs; i++) begin
      rec.task_id      = 8'($urandom_range(0, 255));
      rec.strand       = 2'($urandom_range(0, 3));
      rec.priority_req = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
        rec.priority_req = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
      end
      rec.schedulable  = ($urandom_range(0, 99) < sched_pct);
      rec.last_record  = (i == n_recs - 1);
      send_record(rec, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    int unsigned n_dir;
    int unsigned pick;
    stim_row_t   r;
    sorted_tasks.delete();
    drop_seen = 1'b0;

    // directed table: extremes, skipped records, ties and strand ordering
    dir_tab.push_back(mk_row(8'h00, 2'd0, 8'h00, 1'b0, 1'b1, 1'b1, EmptySched));
    dir_tab.push_back(mk_row(8'hff, 2'd3, 8'hff, 1'b1, 1'b1, 1'b1,
                             {8'hff, 2'd3, 8'hff, 1'b1, 1'b0, 1'b0}));
    dir_tab.push_back(mk_row(8'h00, 2'd0, 8'h00, 1'b1, 1'b1, 1'b1,
                             {8'h00, 2'd0, 8'h00, 1'b1, 1'b0, 1'b0}));
    dir_tab.push_back(mk_row(8'hab, 2'd2, 8'hcd, 1'b0, 1'b1, 1'b1, EmptySched));
    dir_tab.push_back(mk_row(8'h10, 2'd2, 8'h50, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h11, 2'd0, 8'h50, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h12, 2'd2, 8'h80, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h13, 2'd0, 8'h50, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h14, 2'd3, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h15, 2'd1, 8'hff, 1'b0, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h16, 2'd1, 8'hff, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h17, 2'd2, 8'h50, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h18, 2'd0, 8'hff, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h19, 2'd3, 8'hff, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h1a, 2'd1, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h5a, 2'd1, 8'ha5, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'ha5, 2'd1, 8'h5a, 1'b0, 1'b1, 1'b1,
                             {8'h5a, 2'd1, 8'ha5, 1'b1, 1'b0, 1'b0}));
    dir_tab.push_back(mk_row(8'h20, 2'd1, 8'h40, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h21, 2'd1, 8'h40, 1'b1, 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(8'h22, 2'd1, 8'h40, 1'b1, 1'b1, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      send_record(r.rec, r.typed, r.want);
    end
    n_dir = n_sent;
    wait_drained();

    // a load that runs past the store size, then short random loads
    send_load(MaxTasks + $urandom_range(1, 4), 100, 1'b0);
    while (n_sent - n_dir < RandItems) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_load($urandom_range(1, 3), 0, 1'b0);
      end else begin
        send_load($urandom_range(1, 12), 85, pick < 4);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d loads (%0d overflowed, %0d empty) from %0d records",
             n_loads, n_ovf_loads, n_empty, n_sent);
    $display("checked %0d schedule items under random input gaps and output stalls", n_results);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", n_fail);
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("timeout with %0d schedule items outstanding", pending_sched.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
